### rtl/core/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants for the Cartesian/polar converter
// Angle constants in Q.30 radians, the arctangent table, command codes and
// the structures that travel between the front, the queue and the back end.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int ITERATIONS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ANG_BITS       = 30;
  localparam int GUARD          = 16;
  localparam int QUEUE_DEPTH    = 4;

  // Datapath widths of the CORDIC lanes and the angle accumulator.
  localparam int VW = 52;
  localparam int ZW = 34;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 34'sd6746518852;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314857, 30'd497837830, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd1
  };

  localparam logic [1:0] CMD_R2P = 2'd0;
  localparam logic [1:0] CMD_P2R = 2'd1;
  localparam logic [1:0] CMD_ROT = 2'd2;

  typedef enum logic [1:0] {
    KIND_R2P  = 2'd0,
    KIND_P2R  = 2'd1,
    KIND_ROT  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] a;
    logic [31:0] len;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic [31:0]        x;
    logic [31:0]        y;
    logic [31:0]        a;
    logic [31:0]        len;
    logic signed [33:0] rv;
    logic [32:0]        lenr;
  } vec_res_t;

  typedef struct packed {
    logic [31:0] x_out;
    logic [31:0] y_out;
    logic [18:0] angle_out;
    logic [32:0] length_out;
    logic        saturated;
  } res_t;

  // Floor square root, one result bit per pass.
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] rem;
    res   = '0;
    bit_v = 64'd1 << 62;
    rem   = n;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Product of (1 + 2^-2i) over the iterations, in Q.60.
  function automatic logic [63:0] gain_prod(input int n);
    logic [63:0] p;
    p = 64'd1 << 60;
    for (int i = 0; i < 32; i++) begin
      if (i < n) begin
        p = p + (p >> (2 * i));
      end
    end
    return p;
  endfunction

endpackage

### rtl/core/cpc_front.sv
// ----------------------------------------------------------------------------
// cpc_front: input stage
// Registers each incoming word and sorts its command into an operation kind
// before handing it to the queue.
// ----------------------------------------------------------------------------
module cpc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [127:0]        s_tdata,
  input  logic [1:0]          s_tuser,
  output logic                out_valid,
  input  logic                out_ready,
  output cpc_pkg::item_t      out_item
);

  logic              held;
  cpc_pkg::item_t    item;
  cpc_pkg::kind_t    kind_next;

  assign s_tready  = !held || out_ready;
  assign out_valid = held;
  assign out_item  = item;

  always_comb begin
    unique case (s_tuser)
      cpc_pkg::CMD_R2P: kind_next = cpc_pkg::KIND_R2P;
      cpc_pkg::CMD_P2R: kind_next = cpc_pkg::KIND_P2R;
      cpc_pkg::CMD_ROT: kind_next = cpc_pkg::KIND_ROT;
      default:          kind_next = cpc_pkg::KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (out_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.kind <= kind_next;
      item.x    <= s_tdata[31:0];
      item.y    <= s_tdata[63:32];
      item.a    <= s_tdata[95:64];
      item.len  <= s_tdata[127:96];
    end
  end

endmodule

### rtl/core/cpc_queue.sv
// ----------------------------------------------------------------------------
// cpc_queue: short queue between front and back end
// Lets the front keep taking words while the back end is stalled.
// ----------------------------------------------------------------------------
module cpc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cpc_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_take,
  output cpc_pkg::item_t out_item
);

  localparam int DEPTH = cpc_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  cpc_pkg::item_t slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           push;
  logic           pop;

  assign in_ready  = count < (AW + 1)'(DEPTH);
  assign out_valid = count != '0;
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_take && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

### rtl/core/cpc_vec.sv
// ----------------------------------------------------------------------------
// cpc_vec: vectoring section of the back end
// Squares and sums the components, then runs a 32-stage pipelined square
// root alongside the vectoring CORDIC to get length and angle.
// ----------------------------------------------------------------------------
module cpc_vec #(
  parameter int ITERATIONS = cpc_pkg::ITERATIONS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  cpc_pkg::item_t    in_item,
  output logic              out_valid,
  output cpc_pkg::vec_res_t out_res
);

  localparam int VW = cpc_pkg::VW;
  localparam int ZW = cpc_pkg::ZW;
  localparam int GD = cpc_pkg::GUARD;

  typedef struct packed {
    cpc_pkg::kind_t       kind;
    logic [31:0]          x;
    logic [31:0]          y;
    logic [31:0]          a;
    logic [31:0]          len;
    logic                 spec;
    logic signed [ZW-1:0] spec_ang;
    logic signed [ZW-1:0] off;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [ZW-1:0] z;
    logic [63:0]          n;
    logic [31:0]          q;
    logic [33:0]          rem;
  } lane_t;

  // Front stage: squares and vector preparation.
  lane_t                p0;
  logic                 p0_valid;
  logic [63:0]          p0_xx;
  logic [63:0]          p0_yy;

  logic signed [31:0]   xs;
  logic signed [31:0]   ys;
  logic signed [32:0]   xe;
  logic signed [32:0]   ye;
  logic signed [63:0]   xx_c;
  logic signed [63:0]   yy_c;
  logic signed [ZW-1:0] spec_ang_c;
  logic signed [ZW-1:0] off_c;

  assign xs   = $signed(in_item.x);
  assign ys   = $signed(in_item.y);
  assign xx_c = xs * xs;
  assign yy_c = ys * ys;

  always_comb begin
    // Left half plane is folded over by negating both components.
    if (xs < 0) begin
      xe    = -33'(xs);
      ye    = -33'(ys);
      off_c = (ys > 0) ? cpc_pkg::PI_Q30 : -cpc_pkg::PI_Q30;
    end else begin
      xe    = 33'(xs);
      ye    = 33'(ys);
      off_c = '0;
    end
    priority if (xs == 0 && ys == 0) begin
      spec_ang_c = '0;
    end else if (xs == 0) begin
      spec_ang_c = (ys > 0) ? cpc_pkg::HALF_PI_Q30 : -cpc_pkg::HALF_PI_Q30;
    end else if (xs > 0) begin
      spec_ang_c = '0;
    end else begin
      spec_ang_c = -cpc_pkg::PI_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (adv) begin
      p0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0.kind     <= in_item.kind;
      p0.x        <= in_item.x;
      p0.y        <= in_item.y;
      p0.a        <= in_item.a;
      p0.len      <= in_item.len;
      p0.spec     <= (xs == 0) || (ys == 0);
      p0.spec_ang <= spec_ang_c;
      p0.off      <= off_c;
      p0.vx       <= VW'(xe) <<< GD;
      p0.vy       <= VW'(ye) <<< GD;
      p0.z        <= '0;
      p0.n        <= '0;
      p0.q        <= '0;
      p0.rem      <= '0;
      p0_xx       <= 64'(xx_c);
      p0_yy       <= 64'(yy_c);
    end
  end

  // Sum of squares, then the shared square-root / CORDIC lanes.
  lane_t lane [0:32];
  logic  lane_valid [0:32];
  lane_t p0_sum;

  always_comb begin
    p0_sum   = p0;
    p0_sum.n = p0_xx + p0_yy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid[0] <= 1'b0;
    end else if (adv) begin
      lane_valid[0] <= p0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane[0] <= p0_sum;
    end
  end

  for (genvar j = 0; j < 32; j++) begin : g_lane
    localparam int K = 31 - j;
    localparam logic signed [ZW-1:0] AT = ZW'(cpc_pkg::ATAN_Q30[j]);

    lane_t       nxt;
    logic [35:0] remw;
    logic [35:0] trial;

    always_comb begin
      nxt   = lane[j];
      remw  = {lane[j].rem, lane[j].n[2*K+1 -: 2]};
      trial = {2'b00, lane[j].q, 2'b01};
      if (remw >= trial) begin
        nxt.rem = 34'(remw - trial);
        nxt.q   = {lane[j].q[30:0], 1'b1};
      end else begin
        nxt.rem = remw[33:0];
        nxt.q   = {lane[j].q[30:0], 1'b0};
      end
      if (j < ITERATIONS) begin
        if ($signed(lane[j].vy) >= 0) begin
          nxt.vx = $signed(lane[j].vx) + ($signed(lane[j].vy) >>> j);
          nxt.vy = $signed(lane[j].vy) - ($signed(lane[j].vx) >>> j);
          nxt.z  = $signed(lane[j].z) + AT;
        end else begin
          nxt.vx = $signed(lane[j].vx) - ($signed(lane[j].vy) >>> j);
          nxt.vy = $signed(lane[j].vy) + ($signed(lane[j].vx) >>> j);
          nxt.z  = $signed(lane[j].z) - AT;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        lane_valid[j+1] <= 1'b0;
      end else if (adv) begin
        lane_valid[j+1] <= lane_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lane[j+1] <= nxt;
      end
    end
  end

  // Final angle with clamp, and length rounded to nearest.
  logic signed [ZW-1:0] ang_sum;
  logic signed [ZW-1:0] ang_c;

  always_comb begin
    ang_sum = $signed(lane[32].off) + $signed(lane[32].z);
    priority if (lane[32].spec) begin
      ang_c = lane[32].spec_ang;
    end else if (ang_sum > cpc_pkg::PI_Q30) begin
      ang_c = cpc_pkg::PI_Q30;
    end else if (ang_sum < -cpc_pkg::PI_Q30) begin
      ang_c = -cpc_pkg::PI_Q30;
    end else begin
      ang_c = ang_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= lane_valid[32];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res.kind <= lane[32].kind;
      out_res.x    <= lane[32].x;
      out_res.y    <= lane[32].y;
      out_res.a    <= lane[32].a;
      out_res.len  <= lane[32].len;
      out_res.rv   <= ang_c;
      out_res.lenr <= {1'b0, lane[32].q} +
                      33'(lane[32].rem > {2'b00, lane[32].q});
    end
  end

endmodule

### rtl/core/cpc_rot.sv
// ----------------------------------------------------------------------------
// cpc_rot: rotation section of the back end
// Wraps the angle into (-pi, pi] by repeated compare and subtract, scales
// the length by the inverse CORDIC gain, rotates, then rounds, saturates
// and builds the result word.
// ----------------------------------------------------------------------------
module cpc_rot #(
  parameter int ITERATIONS = cpc_pkg::ITERATIONS_DEF,
  parameter int FRAC_BITS  = cpc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  cpc_pkg::vec_res_t in_res,
  output logic              out_valid,
  output cpc_pkg::res_t     out_res
);

  localparam int VW     = cpc_pkg::VW;
  localparam int ZW     = cpc_pkg::ZW;
  localparam int GD     = cpc_pkg::GUARD;
  localparam int ASHIFT = cpc_pkg::ANG_BITS - FRAC_BITS;
  localparam int SW     = 33 + ASHIFT;
  localparam int WW     = SW + 1;
  localparam int NR     = ASHIFT + 1;
  localparam int MSH    = cpc_pkg::ANG_BITS - GD;

  localparam logic [WW-1:0] TWO_PI_W = WW'(cpc_pkg::TWO_PI_Q30);
  localparam logic [WW-1:0] BIAS     = TWO_PI_W << ASHIFT;

  localparam logic [63:0] GP     = cpc_pkg::gain_prod(ITERATIONS);
  localparam logic [63:0] GS     = cpc_pkg::isqrt64(GP);
  localparam logic [63:0] GINV64 = ((64'd1 << 60) + GS / 64'd2) / GS;
  localparam logic [29:0] GINV   = GINV64[29:0];

  localparam logic signed [ZW-1:0] PIO =
    (cpc_pkg::PI_Q30 + (ZW'(1) <<< (ASHIFT - 1))) >>> ASHIFT;

  typedef struct packed {
    cpc_pkg::kind_t       kind;
    logic [31:0]          x;
    logic [31:0]          y;
    logic [31:0]          len;
    logic signed [ZW-1:0] rv;
    logic [32:0]          lenr;
    logic [32:0]          lenp;
    logic [WW-1:0]        w;
  } red_t;

  typedef struct packed {
    cpc_pkg::kind_t       kind;
    logic [31:0]          x;
    logic [31:0]          y;
    logic [31:0]          len;
    logic signed [ZW-1:0] rv;
    logic [32:0]          lenr;
    logic signed [ZW-1:0] r;
    logic [62:0]          prod;
  } wr_t;

  typedef struct packed {
    cpc_pkg::kind_t       kind;
    logic [31:0]          x;
    logic [31:0]          y;
    logic [31:0]          len;
    logic signed [ZW-1:0] rv;
    logic [32:0]          lenr;
    logic signed [ZW-1:0] r;
    logic                 flip;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [ZW-1:0] z;
  } rl_t;

  typedef struct packed {
    cpc_pkg::kind_t       kind;
    logic [31:0]          x;
    logic [31:0]          y;
    logic [31:0]          len;
    logic [32:0]          lenr;
    logic                 flip;
    logic signed [35:0]   rx;
    logic signed [35:0]   ry;
    logic signed [ZW-1:0] ao;
  } o1_t;

  // Angle sum, biased so that the reduction sees a non-negative value.
  red_t              red [0:NR];
  logic              red_valid [0:NR];
  logic signed [SW-1:0] a_ext;
  logic signed [SW-1:0] rv_ext;
  logic signed [SW-1:0] s_sum;

  assign a_ext  = SW'($signed(in_res.a)) <<< ASHIFT;
  assign rv_ext = (in_res.kind == cpc_pkg::KIND_ROT) ? SW'($signed(in_res.rv)) : '0;
  assign s_sum  = a_ext + rv_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_valid[0] <= 1'b0;
    end else if (adv) begin
      red_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red[0].kind <= in_res.kind;
      red[0].x    <= in_res.x;
      red[0].y    <= in_res.y;
      red[0].len  <= in_res.len;
      red[0].rv   <= in_res.rv;
      red[0].lenr <= in_res.lenr;
      red[0].lenp <= (in_res.kind == cpc_pkg::KIND_ROT) ? in_res.lenr
                                                        : {1'b0, in_res.len};
      red[0].w    <= WW'(s_sum) + BIAS;
    end
  end

  for (genvar s = 0; s < NR; s++) begin : g_red
    localparam logic [WW-1:0] STEP = TWO_PI_W << (ASHIFT - s);

    red_t nxt;

    always_comb begin
      nxt = red[s];
      if (red[s].w >= STEP) begin
        nxt.w = red[s].w - STEP;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        red_valid[s+1] <= 1'b0;
      end else if (adv) begin
        red_valid[s+1] <= red_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        red[s+1] <= nxt;
      end
    end
  end

  // Move the remainder into (-pi, pi]; scale the length by 1/K.
  wr_t                  w3;
  logic                 w3_valid;
  logic signed [ZW-1:0] wv;

  assign wv = $signed({1'b0, red[NR].w[32:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      w3_valid <= 1'b0;
    end else if (adv) begin
      w3_valid <= red_valid[NR];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w3.kind <= red[NR].kind;
      w3.x    <= red[NR].x;
      w3.y    <= red[NR].y;
      w3.len  <= red[NR].len;
      w3.rv   <= red[NR].rv;
      w3.lenr <= red[NR].lenr;
      w3.r    <= (wv > cpc_pkg::PI_Q30) ? wv - cpc_pkg::TWO_PI_Q30 : wv;
      w3.prod <= 63'(red[NR].lenp) * 63'(GINV);
    end
  end

  // Fold the angle into the right half plane and seed the rotation.
  rl_t                  rl [0:ITERATIONS];
  logic                 rl_valid [0:ITERATIONS];
  logic signed [ZW-1:0] rr_c;
  logic                 flip_c;
  logic [63:0]          seed_c;

  always_comb begin
    priority if (w3.r > cpc_pkg::HALF_PI_Q30) begin
      rr_c   = w3.r - cpc_pkg::PI_Q30;
      flip_c = 1'b1;
    end else if (w3.r < -cpc_pkg::HALF_PI_Q30) begin
      rr_c   = w3.r + cpc_pkg::PI_Q30;
      flip_c = 1'b1;
    end else begin
      rr_c   = w3.r;
      flip_c = 1'b0;
    end
    seed_c = (64'(w3.prod) + (64'd1 << (MSH - 1))) >> MSH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rl_valid[0] <= 1'b0;
    end else if (adv) begin
      rl_valid[0] <= w3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rl[0].kind <= w3.kind;
      rl[0].x    <= w3.x;
      rl[0].y    <= w3.y;
      rl[0].len  <= w3.len;
      rl[0].rv   <= w3.rv;
      rl[0].lenr <= w3.lenr;
      rl[0].r    <= w3.r;
      rl[0].flip <= flip_c;
      rl[0].vx   <= $signed(seed_c[VW-1:0]);
      rl[0].vy   <= '0;
      rl[0].z    <= rr_c;
    end
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    localparam logic signed [ZW-1:0] AT = ZW'(cpc_pkg::ATAN_Q30[i]);

    rl_t nxt;

    always_comb begin
      nxt = rl[i];
      if ($signed(rl[i].z) >= 0) begin
        nxt.vx = $signed(rl[i].vx) - ($signed(rl[i].vy) >>> i);
        nxt.vy = $signed(rl[i].vy) + ($signed(rl[i].vx) >>> i);
        nxt.z  = $signed(rl[i].z) - AT;
      end else begin
        nxt.vx = $signed(rl[i].vx) + ($signed(rl[i].vy) >>> i);
        nxt.vy = $signed(rl[i].vy) - ($signed(rl[i].vx) >>> i);
        nxt.z  = $signed(rl[i].z) + AT;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rl_valid[i+1] <= 1'b0;
      end else if (adv) begin
        rl_valid[i+1] <= rl_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rl[i+1] <= nxt;
      end
    end
  end

  // Round the components and the angle field.
  o1_t                  o1;
  logic                 o1_valid;
  logic signed [ZW-1:0] ang_sel;
  rl_t                  rlast;

  assign rlast   = rl[ITERATIONS];
  assign ang_sel = (rlast.kind == cpc_pkg::KIND_R2P) ? rlast.rv : rlast.r;

  always_ff @(posedge clk) begin
    if (rst) begin
      o1_valid <= 1'b0;
    end else if (adv) begin
      o1_valid <= rl_valid[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o1.kind <= rlast.kind;
      o1.x    <= rlast.x;
      o1.y    <= rlast.y;
      o1.len  <= rlast.len;
      o1.lenr <= rlast.lenr;
      o1.flip <= rlast.flip;
      o1.rx   <= 36'(($signed(rlast.vx) + (VW'(1) <<< (GD - 1))) >>> GD);
      o1.ry   <= 36'(($signed(rlast.vy) + (VW'(1) <<< (GD - 1))) >>> GD);
      o1.ao   <= ($signed(ang_sel) + (ZW'(1) <<< (ASHIFT - 1))) >>> ASHIFT;
    end
  end

  // Undo the fold, saturate, and build the result word.
  logic signed [36:0]   fx;
  logic signed [36:0]   fy;
  logic [31:0]          sx;
  logic [31:0]          sy;
  logic                 sat_x;
  logic                 sat_y;
  logic signed [ZW-1:0] ao_c;
  cpc_pkg::res_t        res_c;

  always_comb begin
    fx = o1.flip ? -37'(o1.rx) : 37'(o1.rx);
    fy = o1.flip ? -37'(o1.ry) : 37'(o1.ry);
    sat_x = 1'b1;
    sat_y = 1'b1;
    priority if (fx > 37'sh0_7FFF_FFFF) begin
      sx = 32'h7FFF_FFFF;
    end else if (fx < -37'sh0_8000_0000) begin
      sx = 32'h8000_0000;
    end else begin
      sx    = fx[31:0];
      sat_x = 1'b0;
    end
    priority if (fy > 37'sh0_7FFF_FFFF) begin
      sy = 32'h7FFF_FFFF;
    end else if (fy < -37'sh0_8000_0000) begin
      sy = 32'h8000_0000;
    end else begin
      sy    = fy[31:0];
      sat_y = 1'b0;
    end
    priority if (o1.ao > PIO) begin
      ao_c = PIO;
    end else if (o1.ao < -PIO) begin
      ao_c = -PIO;
    end else begin
      ao_c = o1.ao;
    end

    unique case (o1.kind)
      cpc_pkg::KIND_R2P: begin
        res_c.x_out      = o1.x;
        res_c.y_out      = o1.y;
        res_c.angle_out  = ao_c[18:0];
        res_c.length_out = o1.lenr;
        res_c.saturated  = 1'b0;
      end
      cpc_pkg::KIND_P2R: begin
        res_c.x_out      = sx;
        res_c.y_out      = sy;
        res_c.angle_out  = ao_c[18:0];
        res_c.length_out = {1'b0, o1.len};
        res_c.saturated  = sat_x || sat_y;
      end
      cpc_pkg::KIND_ROT: begin
        res_c.x_out      = sx;
        res_c.y_out      = sy;
        res_c.angle_out  = ao_c[18:0];
        res_c.length_out = o1.lenr;
        res_c.saturated  = sat_x || sat_y;
      end
      default: begin
        res_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= o1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res_c;
    end
  end

endmodule

### rtl/core/cartesian_polar_conversion.sv
// ----------------------------------------------------------------------------
// cartesian_polar_conversion: CORDIC rectangular/polar converter
//
//   Channel | Direction | tdata (low bit up)               | tuser
//   --------+-----------+----------------------------------+-----------------
//   s_*     | in        | x_in, y_in, angle_in, length_in  | command
//   m_*     | out       | x_out, y_out, angle_out,         | saturated
//           |           | length_out, zero pad to 120 bits |
//
// One word is taken per cycle while the queue has room. The back end
// contains the 32-step square root, the angle reduction of 31 - FRAC_BITS
// steps and the ITERATIONS-step rotation CORDIC.
// The back end pipeline holds while m_tready is low with a result waiting;
// the input register and a four-word queue keep taking words until full.
// Reset clears the valid bits and the queue pointers only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cartesian_polar_conversion #(
  parameter int ITERATIONS = cpc_pkg::ITERATIONS_DEF,
  parameter int FRAC_BITS  = cpc_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // x_in, y_in, angle_in, length_in
  input  logic [1:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // x_out, y_out, angle_out, length_out, pad
  output logic [0:0]   m_tuser    // saturated
);

  logic              fr_valid;
  logic              q_ready;
  cpc_pkg::item_t    fr_item;
  logic              q_valid;
  cpc_pkg::item_t    q_item;
  logic              adv;
  logic              v_valid;
  cpc_pkg::vec_res_t v_res;
  cpc_pkg::res_t     res;

  // The whole back end moves together whenever the output slot can move.
  assign adv = !m_tvalid || m_tready;

  cpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .out_valid (fr_valid),
    .out_ready (q_ready),
    .out_item  (fr_item)
  );

  cpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (q_ready),
    .in_item   (fr_item),
    .out_valid (q_valid),
    .out_take  (adv),
    .out_item  (q_item)
  );

  cpc_vec #(
    .ITERATIONS (ITERATIONS)
  ) u_vec (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .out_valid (v_valid),
    .out_res   (v_res)
  );

  cpc_rot #(
    .ITERATIONS (ITERATIONS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_rot (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v_valid),
    .in_res    (v_res),
    .out_valid (m_tvalid),
    .out_res   (res)
  );

  assign m_tdata = {4'b0000, res.length_out, res.angle_out, res.y_out, res.x_out};
  assign m_tuser = res.saturated;

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the CORDIC Cartesian/polar converter
// Words for all three commands and the unused command code are sent through
// the slave stream. Each accepted word is run through an in-bench model of the
// converter, and the expected result is queued. Results from the master stream
// are compared field by field in arrival order. Both sides idle at random, and
// one long receiver hold-off backs the pipe up to the input.
// ----------------------------------------------------------------------------
module tb;

  localparam int ASHIFT    = cpc_pkg::ANG_BITS - cpc_pkg::FRAC_BITS_DEF;
  localparam int WDOG_MAX  = 5000;
  localparam int TAIL_WAIT = 200;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [1:0]   s_tuser = cpc_pkg::CMD_R2P;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;
  logic [0:0]   m_tuser;

  cpc_pkg::res_t expected_res[$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   sent_per_cmd[4] = '{0, 0, 0, 0};
  int   sat_seen = 0;
  bit   idling_on = 1'b1;
  bit   hold_req = 1'b0;
  bit   holding = 1'b0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  cartesian_polar_conversion DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned root_nearest(longint unsigned n);
    longint unsigned s;
    s = root_floor(n);
    if (n - s * s > s) s++;
    return s;
  endfunction

  function automatic longint rshift_round(longint v, int s);
    longint one;
    one = 1;
    return (v + (one <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [18:0] angle_to_field(longint r);
    longint o, pio;
    o = rshift_round(r, ASHIFT);
    pio = rshift_round(cpc_pkg::PI_Q30, ASHIFT);
    if (o > pio) o = pio;
    if (o < -pio) o = -pio;
    return o[18:0];
  endfunction

  function automatic longint wrap_pi(longint a);
    longint r, two_pi, pi;
    two_pi = cpc_pkg::TWO_PI_Q30;
    pi = cpc_pkg::PI_Q30;
    r = a % two_pi;
    if (r < 0) r += two_pi;
    if (r > pi) r -= two_pi;
    return r;
  endfunction

  function automatic longint heading(longint x, longint y);
    longint off, vx, vy, z, dx, dy, r, t, pi, hpi;
    pi = cpc_pkg::PI_Q30;
    hpi = cpc_pkg::HALF_PI_Q30;
    off = 0;
    vx = x;
    vy = y;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x == 0) return (y > 0) ? hpi : -hpi;
    if (y == 0) return (x > 0) ? 0 : -pi;
    if (x < 0) begin
      vx = -vx;
      vy = -vy;
      off = (y > 0) ? pi : -pi;
    end
    vx = vx <<< cpc_pkg::GUARD;
    vy = vy <<< cpc_pkg::GUARD;
    for (int i = 0; i < cpc_pkg::ITERATIONS_DEF; i++) begin
      t = cpc_pkg::ATAN_Q30[i];
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx += dx; vy -= dy; z += t;
      end else begin
        vx -= dx; vy += dy; z -= t;
      end
    end
    r = off + z;
    if (r > pi) r = pi;
    if (r < -pi) r = -pi;
    return r;
  endfunction

  function automatic longint unsigned cordic_inv_gain();
    longint unsigned p, s;
    p = 64'd1 << 60;
    for (int i = 0; i < cpc_pkg::ITERATIONS_DEF; i++) p += p >> (2 * i);
    s = root_floor(p);
    return ((64'd1 << 60) + s / 2) / s;
  endfunction

  function automatic longint clip32(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic void rotate_out(input longint r_in, input longint unsigned len,
                                     output longint xo, output longint yo,
                                     ref bit sat);
    bit flip;
    longint r, vx, vy, z, nx, t, rx, ry, pi, hpi;
    longint unsigned scaled;
    pi = cpc_pkg::PI_Q30;
    hpi = cpc_pkg::HALF_PI_Q30;
    r = r_in;
    flip = 1'b0;
    vy = 0;
    if (r > hpi) begin
      r -= pi; flip = 1'b1;
    end else if (r < -hpi) begin
      r += pi; flip = 1'b1;
    end
    scaled = (len * cordic_inv_gain() +
              (64'd1 << (cpc_pkg::ANG_BITS - cpc_pkg::GUARD - 1)))
             >> (cpc_pkg::ANG_BITS - cpc_pkg::GUARD);
    vx = longint'(scaled);
    z = r;
    for (int i = 0; i < cpc_pkg::ITERATIONS_DEF; i++) begin
      t = cpc_pkg::ATAN_Q30[i];
      if (z >= 0) begin
        nx = vx - (vy >>> i); vy += vx >>> i; vx = nx; z -= t;
      end else begin
        nx = vx + (vy >>> i); vy -= vx >>> i; vx = nx; z += t;
      end
    end
    rx = rshift_round(vx, cpc_pkg::GUARD);
    ry = rshift_round(vy, cpc_pkg::GUARD);
    if (flip) begin
      rx = -rx; ry = -ry;
    end
    xo = clip32(rx, sat);
    yo = clip32(ry, sat);
  endfunction

  function automatic cpc_pkg::res_t convert(logic [1:0] cmd, logic [31:0] xi,
                                            logic [31:0] yi, logic [31:0] ai,
                                            logic [31:0] li);
    cpc_pkg::res_t o;
    longint x, y, a, xo, yo, r;
    longint unsigned len, lo;
    bit sat;
    x = longint'(signed'(xi));
    y = longint'(signed'(yi));
    a = longint'(signed'(ai));
    len = li;
    o = '0;
    sat = 1'b0;
    case (cmd)
      cpc_pkg::CMD_R2P: begin
        o.x_out = xi;
        o.y_out = yi;
        o.angle_out = angle_to_field(heading(x, y));
        lo = root_nearest(longint'(x * x) + longint'(y * y));
        o.length_out = lo[32:0];
      end
      cpc_pkg::CMD_P2R: begin
        r = wrap_pi(a <<< ASHIFT);
        rotate_out(r, len, xo, yo, sat);
        o.x_out = xo[31:0];
        o.y_out = yo[31:0];
        o.angle_out = angle_to_field(r);
        o.length_out = {1'b0, li};
      end
      cpc_pkg::CMD_ROT: begin
        lo = root_nearest(longint'(x * x) + longint'(y * y));
        r = wrap_pi(heading(x, y) + (a <<< ASHIFT));
        rotate_out(r, lo, xo, yo, sat);
        o.x_out = xo[31:0];
        o.y_out = yo[31:0];
        o.angle_out = angle_to_field(r);
        o.length_out = lo[32:0];
      end
      default: o = '0;
    endcase
    o.saturated = sat;
    return o;
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic send_word(input logic [1:0] cmd, input logic [31:0] xi,
                           input logic [31:0] yi, input logic [31:0] ai,
                           input logic [31:0] li);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {li, ai, yi, xi};
    do @(posedge clk); while (!s_tready);
    expected_res.push_back(convert(cmd, xi, yi, ai, li));
    sent_per_cmd[cmd]++;
  endtask

  task automatic send_random();
    logic [1:0] cmd;
    logic [31:0] v[4];
    int pick;
    cmd = ($urandom_range(0, 40) == 0) ? 2'(cpc_pkg::KIND_NONE)
                                       : 2'($urandom_range(0, 2));
    for (int k = 0; k < 4; k++) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0: v[k] = $urandom_range(0, 8) - 4;
        1: v[k] = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        2: v[k] = {32{1'b0}} | $urandom_range(0, 3) * 32'd102944 - 32'd102944;
        3: v[k] = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
        default: v[k] = $urandom;
      endcase
      if (k < 2 && $urandom_range(0, 9) == 0) v[k] = '0;
    end
    send_word(cmd, v[0], v[1], v[2], v[3]);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    // Origin, the four axes, extreme coordinates.
    send_word(cpc_pkg::CMD_R2P, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(cpc_pkg::CMD_R2P, 32'h00010000, 32'd0, 32'd0, 32'd0);
    send_word(cpc_pkg::CMD_R2P, 32'd0, 32'h00010000, 32'd0, 32'd0);
    send_word(cpc_pkg::CMD_R2P, 32'hFFFF0000, 32'd0, 32'd0, 32'd0);
    send_word(cpc_pkg::CMD_R2P, 32'd0, 32'hFFFF0000, 32'd0, 32'd0);
    send_word(cpc_pkg::CMD_R2P, 32'h80000000, 32'h80000000, 32'd0, 32'd0);
    send_word(cpc_pkg::CMD_R2P, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0, 32'd0);
    send_word(cpc_pkg::CMD_R2P, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_word(cpc_pkg::CMD_R2P, 32'hFFFF0000, 32'h00000001, 32'd0, 32'd0);
    // Polar to rectangular: zero, pi, -pi, beyond two pi, huge angles.
    send_word(cpc_pkg::CMD_P2R, 32'd0, 32'd0, 32'd0, 32'h00010000);
    send_word(cpc_pkg::CMD_P2R, 32'd0, 32'd0, 32'd205887, 32'h00010000);
    send_word(cpc_pkg::CMD_P2R, 32'd0, 32'd0, -32'sd205887, 32'h00010000);
    send_word(cpc_pkg::CMD_P2R, 32'd0, 32'd0, 32'd900000, 32'h00020000);
    send_word(cpc_pkg::CMD_P2R, 32'd0, 32'd0, 32'h7FFFFFFF, 32'h00010000);
    send_word(cpc_pkg::CMD_P2R, 32'd0, 32'd0, 32'h80000000, 32'h00010000);
    send_word(cpc_pkg::CMD_P2R, 32'd0, 32'd0, 32'd0, 32'hFFFFFFFF);
    send_word(cpc_pkg::CMD_P2R, 32'd0, 32'd0, 32'd51472, 32'hFFFFFFFF);
    send_word(cpc_pkg::CMD_P2R, 32'd0, 32'd0, 32'd102944, 32'd0);
    // Rotation, including one that clips the result.
    send_word(cpc_pkg::CMD_ROT, 32'h00010000, 32'd0, 32'd102944, 32'd0);
    send_word(cpc_pkg::CMD_ROT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0, 32'd0);
    send_word(cpc_pkg::CMD_ROT, 32'h80000000, 32'h80000000, 32'd51472, 32'd0);
    send_word(cpc_pkg::CMD_ROT, 32'd0, 32'd0, 32'd12345, 32'd7);
    send_word(cpc_pkg::CMD_ROT, 32'hFFFF0000, 32'd0, 32'h80000000, 32'd0);
    // Unused command code answers with all fields zero.
    send_word(2'(cpc_pkg::KIND_NONE), 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F,
              32'hF0F0F0F0);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_random();
  endtask

  task automatic test_backpressure();
    // Receiver holds off while the sender keeps offering more words than the
    // pipeline and queue can hold, so the input stalls.
    hold_req = 1'b1;
    for (int i = 0; i < 150; i++) send_random();
  endtask

  task automatic test_no_idle(input int n);
    idling_on = 1'b0;
    for (int i = 0; i < n; i++) send_random();
  endtask

  // ---------------------------------------------------------------- receiver
  int hold_count = 0;
  always @(posedge clk) begin
    if (hold_req && !holding) begin
      holding <= 1'b1;
      hold_count <= 400;
    end else if (holding) begin
      if (hold_count == 1) begin
        holding <= 1'b0;
        hold_req <= 1'b0;
      end
      hold_count <= hold_count - 1;
    end
  end

  always @(posedge clk) begin
    logic ready_next;
    ready_next = 1'b1;
    if (rst || holding || (hold_req && !holding)) begin
      ready_next = 1'b0;
    end else if (stall_left > 0) begin
      ready_next = 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      ready_next = 1'b0;
      stall_left <= $urandom_range(0, 3);
    end
    m_tready <= ready_next;
  end

  always @(posedge clk) begin
    cpc_pkg::res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.x_out = m_tdata[31:0];
      got.y_out = m_tdata[63:32];
      got.angle_out = m_tdata[82:64];
      got.length_out = m_tdata[115:83];
      got.saturated = m_tuser[0];
      results_seen++;
      if (got.saturated) sat_seen++;
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: %p", got);
      end else begin
        want = expected_res.pop_front();
        if (got.x_out !== want.x_out || got.y_out !== want.y_out ||
            got.angle_out !== want.angle_out || got.length_out !== want.length_out ||
            got.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch at result %0d: expected x=%h y=%h ang=%h len=%h ",
                      "sat=%b, got x=%h y=%h ang=%h len=%h sat=%b"},
                     results_seen, want.x_out, want.y_out, want.angle_out,
                     want.length_out, want.saturated, got.x_out, got.y_out,
                     got.angle_out, got.length_out, got.saturated);
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (!s_tvalid && expected_res.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure();
    test_random(400);
    test_no_idle(260);
    s_tvalid <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    $display("Covered %0d rect-to-polar, %0d polar-to-rect, %0d rotate, %0d unused-code",
             sent_per_cmd[0], sent_per_cmd[1], sent_per_cmd[2], sent_per_cmd[3]);
    $display("words; %0d results checked, %0d saturated, %0d mismatches.",
             results_seen, sat_seen, mismatches);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/cpc_pkg.sv
rtl/core/cpc_front.sv
rtl/core/cpc_queue.sv
rtl/core/cpc_vec.sv
rtl/core/cpc_rot.sv
rtl/core/cartesian_polar_conversion.sv
bench/tb.sv
